// File: rtl/ibcc_pkg.sv
// Shared types and constants for the IMU bias calibration and conversion block.
// Holds the sequencer state type, status and register codes and divider port types.
// Depends on nothing.
package ibcc_pkg;

  localparam int unsigned NUM_CH   = 6;
  localparam int unsigned RAW_W    = 16;
  localparam int unsigned VAL_W    = 21;
  localparam int unsigned SUM_W    = 32;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned GAIN_W   = 24;
  localparam int unsigned ONEG_W   = 15;
  localparam int unsigned CFG_IX_W = 3;
  localparam int unsigned CFG_D_W  = 24;
  localparam int unsigned STATUS_W = 3;

  localparam logic [STATUS_W-1:0] STATUS_MEASURED    = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_CALIB_TAKEN = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_CALIB_DONE  = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_CALIB_FAIL  = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_REJECTED    = 3'd4;

  localparam logic [CFG_IX_W-1:0] CFG_SENSOR_PRESENT = 3'd0;
  localparam logic [CFG_IX_W-1:0] CFG_CALIB_SAMPLES  = 3'd1;
  localparam logic [CFG_IX_W-1:0] CFG_ACCEL_ONE_G    = 3'd2;
  localparam logic [CFG_IX_W-1:0] CFG_ACCEL_GAIN     = 3'd3;
  localparam logic [CFG_IX_W-1:0] CFG_GYRO_GAIN      = 3'd4;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ACC  = 5'b00010,
    S_DIV  = 5'b00100,
    S_MEAS = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/ibcc_div.sv
// Unsigned restoring divider producing one quotient bit per cycle.
// Uses the divider request and response types from ibcc_pkg.
module ibcc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ibcc_pkg::div_req_t req_i,
  output ibcc_pkg::div_rsp_t rsp_o
);

  logic                         busy_q;
  logic                         done_q;
  logic [4:0]                   step_q;
  logic [ibcc_pkg::CNT_W-1:0]   rem_q;
  logic [ibcc_pkg::SUM_W-1:0]   quo_q;
  logic [ibcc_pkg::CNT_W-1:0]   dvs_q;
  logic [ibcc_pkg::CNT_W:0]     shifted;
  logic [ibcc_pkg::CNT_W:0]     diff;
  logic                         fits;

  assign shifted = {rem_q, quo_q[ibcc_pkg::SUM_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 5'd1;
        if (step_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= fits ? diff[ibcc_pkg::CNT_W-1:0] : shifted[ibcc_pkg::CNT_W-1:0];
      quo_q <= {quo_q[ibcc_pkg::SUM_W-2:0], fits};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// File: rtl/imu_bias_calibrate_convert_core.sv
// Top level of the IMU bias calibration and scaling block.
// Depends on ibcc_pkg and instantiates the shared divider ibcc_div.
//
// Usage: an input transfer carries an operation flag, a read-ok flag and six
// raw readings; each produces exactly one output transfer carrying a status and
// six values. Registers are to be written through the plain write port only
// while idle; the block itself does not enforce this. The input is taken
// only while the sequencer is idle. A rejected item goes straight to the done
// state, from which its result loads into the output register. A calibration
// sample updates one running sum per cycle in a shared adder. A measurement
// scales one axis per cycle in a shared multiplier. The item that completes a
// calibration run with a nonzero good count then divides six sums by that count
// in the shared divider, one sum after another, and its result loads once the
// last quotient is in. The output register lets the next item be accepted
// while a result still waits for its receiver; a stalled receiver holds the
// result, and the finished next item then waits in its last state until the
// register frees.
// Reset clears sums, offsets and counts and loads the register defaults.
module imu_bias_calibrate_convert_core (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [ibcc_pkg::CFG_IX_W-1:0]           cfg_index_i,
  input  logic [ibcc_pkg::CFG_D_W-1:0]            cfg_data_i,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic                                    op_i,
  input  logic                                    sample_ok_i,
  input  logic signed [ibcc_pkg::RAW_W-1:0]       accel_x_raw_i,
  input  logic signed [ibcc_pkg::RAW_W-1:0]       accel_y_raw_i,
  input  logic signed [ibcc_pkg::RAW_W-1:0]       accel_z_raw_i,
  input  logic signed [ibcc_pkg::RAW_W-1:0]       gyro_x_raw_i,
  input  logic signed [ibcc_pkg::RAW_W-1:0]       gyro_y_raw_i,
  input  logic signed [ibcc_pkg::RAW_W-1:0]       gyro_z_raw_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic [ibcc_pkg::STATUS_W-1:0]           status_o,
  output logic signed [ibcc_pkg::VAL_W-1:0]       accel_x_val_o,
  output logic signed [ibcc_pkg::VAL_W-1:0]       accel_y_val_o,
  output logic signed [ibcc_pkg::VAL_W-1:0]       accel_z_val_o,
  output logic signed [ibcc_pkg::VAL_W-1:0]       gyro_x_val_o,
  output logic signed [ibcc_pkg::VAL_W-1:0]       gyro_y_val_o,
  output logic signed [ibcc_pkg::VAL_W-1:0]       gyro_z_val_o
);

  localparam int unsigned PROD_W = ibcc_pkg::RAW_W + 1 + ibcc_pkg::GAIN_W + 1;

  ibcc_pkg::state_e state_q;
  logic [2:0]       cnt_q;
  logic [2:0]       ch;
  logic             in_fire;

  logic                         present_q;
  logic [ibcc_pkg::CNT_W-1:0]   calib_q;
  logic [ibcc_pkg::ONEG_W-1:0]  one_g_q;
  logic [ibcc_pkg::GAIN_W-1:0]  again_q;
  logic [ibcc_pkg::GAIN_W-1:0]  ggain_q;

  logic [ibcc_pkg::SUM_W-1:0]   sums_q [ibcc_pkg::NUM_CH];
  logic [ibcc_pkg::RAW_W-1:0]   offs_q [ibcc_pkg::NUM_CH];
  logic [ibcc_pkg::CNT_W-1:0]   seen_q;
  logic [ibcc_pkg::CNT_W-1:0]   good_q;

  logic [ibcc_pkg::RAW_W-1:0]   raw_q  [ibcc_pkg::NUM_CH];
  logic                         ok_q;
  logic [ibcc_pkg::VAL_W-1:0]   val_q  [ibcc_pkg::NUM_CH];
  logic [ibcc_pkg::STATUS_W-1:0] status_q;
  logic signed [PROD_W-1:0]     prod_q;

  logic                          out_valid_q;
  logic [ibcc_pkg::STATUS_W-1:0] out_status_q;
  logic [ibcc_pkg::VAL_W-1:0]    out_val_q [ibcc_pkg::NUM_CH];
  logic                          out_load;

  logic                         div_start_q;
  ibcc_pkg::div_req_t           div_req;
  ibcc_pkg::div_rsp_t           div_rsp;

  logic [ibcc_pkg::SUM_W-1:0]   sum_sel;
  logic [ibcc_pkg::SUM_W-1:0]   sum_add;
  logic [ibcc_pkg::RAW_W-1:0]   quo16;
  logic [ibcc_pkg::RAW_W-1:0]   new_off;
  logic signed [ibcc_pkg::RAW_W:0] diff_m;
  logic [ibcc_pkg::GAIN_W-1:0]  gain_sel;
  logic signed [PROD_W-1:0]     prod_d;
  logic [PROD_W-17:0]           shifted_p;
  logic [ibcc_pkg::VAL_W-1:0]   sat_val;

  assign in_ready_o = (state_q == ibcc_pkg::S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign ch         = (cnt_q < 3'd6) ? cnt_q : 3'd0;
  assign out_load   = (state_q == ibcc_pkg::S_DONE) && (!out_valid_q || out_ready_i);

  assign sum_sel = sums_q[ch];
  assign sum_add = sum_sel + {{(ibcc_pkg::SUM_W - ibcc_pkg::RAW_W){raw_q[ch][15]}}, raw_q[ch]};

  assign div_req.start    = div_start_q;
  assign div_req.dividend = sum_sel[ibcc_pkg::SUM_W-1] ? (~sum_sel + 32'd1) : sum_sel;
  assign div_req.divisor  = good_q;

  ibcc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign quo16   = sum_sel[ibcc_pkg::SUM_W-1] ? (~div_rsp.quotient[15:0] + 16'd1)
                                              : div_rsp.quotient[15:0];
  assign new_off = (ch == 3'd2) ? (quo16 - {1'b0, one_g_q}) : quo16;

  assign diff_m   = $signed({raw_q[ch][15], raw_q[ch]}) - $signed({offs_q[ch][15], offs_q[ch]});
  assign gain_sel = (ch < 3'd3) ? again_q : ggain_q;
  assign prod_d   = PROD_W'(diff_m) * $signed({1'b0, gain_sel});

  assign shifted_p = prod_q[PROD_W-1:16];
  always_comb begin
    if (!shifted_p[PROD_W-17] && (shifted_p[PROD_W-18:20] != '0)) begin
      sat_val = {1'b0, {(ibcc_pkg::VAL_W-1){1'b1}}};
    end else if (shifted_p[PROD_W-17] && (shifted_p[PROD_W-18:20] != '1)) begin
      sat_val = {1'b1, {(ibcc_pkg::VAL_W-1){1'b0}}};
    end else begin
      sat_val = shifted_p[ibcc_pkg::VAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ibcc_pkg::S_IDLE;
      cnt_q       <= '0;
      present_q   <= 1'b0;
      calib_q     <= 16'd200;
      one_g_q     <= 15'd16384;
      again_q     <= 24'd10042;
      ggain_q     <= 24'd128075;
      seen_q      <= '0;
      good_q      <= '0;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < ibcc_pkg::NUM_CH; i++) begin
        sums_q[i] <= '0;
        offs_q[i] <= '0;
      end
    end else begin
      div_start_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_index_i)
          ibcc_pkg::CFG_SENSOR_PRESENT: present_q <= cfg_data_i[0];
          ibcc_pkg::CFG_CALIB_SAMPLES:  calib_q   <= cfg_data_i[ibcc_pkg::CNT_W-1:0];
          ibcc_pkg::CFG_ACCEL_ONE_G:    one_g_q   <= cfg_data_i[ibcc_pkg::ONEG_W-1:0];
          ibcc_pkg::CFG_ACCEL_GAIN:     again_q   <= cfg_data_i;
          ibcc_pkg::CFG_GYRO_GAIN:      ggain_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ibcc_pkg::S_IDLE: begin
          cnt_q <= '0;
          if (in_fire) begin
            if (!present_q || (op_i && !sample_ok_i)) begin
              state_q <= ibcc_pkg::S_DONE;
            end else if (op_i) begin
              state_q <= ibcc_pkg::S_MEAS;
            end else begin
              state_q <= ibcc_pkg::S_ACC;
              seen_q  <= seen_q + 16'd1;
              good_q  <= good_q + {15'd0, sample_ok_i};
            end
          end
        end
        ibcc_pkg::S_ACC: begin
          if (ok_q) begin
            sums_q[ch] <= sum_add;
          end
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd5) begin
            cnt_q <= '0;
            if (seen_q < calib_q) begin
              state_q <= ibcc_pkg::S_DONE;
            end else if (good_q == '0) begin
              state_q <= ibcc_pkg::S_DONE;
              seen_q  <= '0;
              for (int i = 0; i < ibcc_pkg::NUM_CH; i++) begin
                sums_q[i] <= '0;
              end
            end else begin
              state_q     <= ibcc_pkg::S_DIV;
              div_start_q <= 1'b1;
            end
          end
        end
        ibcc_pkg::S_DIV: begin
          if (div_rsp.done) begin
            offs_q[ch] <= new_off;
            if (cnt_q == 3'd5) begin
              state_q <= ibcc_pkg::S_DONE;
              seen_q  <= '0;
              good_q  <= '0;
              for (int i = 0; i < ibcc_pkg::NUM_CH; i++) begin
                sums_q[i] <= '0;
              end
            end else begin
              cnt_q       <= cnt_q + 3'd1;
              div_start_q <= 1'b1;
            end
          end
        end
        ibcc_pkg::S_MEAS: begin
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd6) begin
            state_q <= ibcc_pkg::S_DONE;
          end
        end
        ibcc_pkg::S_DONE: begin
          if (out_load) begin
            state_q <= ibcc_pkg::S_IDLE;
          end
        end
        default: state_q <= ibcc_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      raw_q[0] <= accel_x_raw_i;
      raw_q[1] <= accel_y_raw_i;
      raw_q[2] <= accel_z_raw_i;
      raw_q[3] <= gyro_x_raw_i;
      raw_q[4] <= gyro_y_raw_i;
      raw_q[5] <= gyro_z_raw_i;
      ok_q     <= sample_ok_i;
      for (int i = 0; i < ibcc_pkg::NUM_CH; i++) begin
        val_q[i] <= '0;
      end
      if (!present_q || (op_i && !sample_ok_i)) begin
        status_q <= ibcc_pkg::STATUS_REJECTED;
      end else if (op_i) begin
        status_q <= ibcc_pkg::STATUS_MEASURED;
      end else begin
        status_q <= ibcc_pkg::STATUS_CALIB_TAKEN;
      end
    end
    if ((state_q == ibcc_pkg::S_ACC) && (cnt_q == 3'd5) && !(seen_q < calib_q)
        && (good_q == '0)) begin
      status_q <= ibcc_pkg::STATUS_CALIB_FAIL;
    end
    if ((state_q == ibcc_pkg::S_DIV) && div_rsp.done) begin
      val_q[ch] <= {{(ibcc_pkg::VAL_W - ibcc_pkg::RAW_W){new_off[15]}}, new_off};
      status_q  <= ibcc_pkg::STATUS_CALIB_DONE;
    end
    if (state_q == ibcc_pkg::S_MEAS) begin
      prod_q <= prod_d;
      if (cnt_q != 3'd0) begin
        val_q[cnt_q - 3'd1] <= sat_val;
      end
    end
    if (out_load) begin
      out_status_q <= status_q;
      for (int i = 0; i < ibcc_pkg::NUM_CH; i++) begin
        out_val_q[i] <= val_q[i];
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign accel_x_val_o = out_val_q[0];
  assign accel_y_val_o = out_val_q[1];
  assign accel_z_val_o = out_val_q[2];
  assign gyro_x_val_o  = out_val_q[3];
  assign gyro_y_val_o  = out_val_q[4];
  assign gyro_z_val_o  = out_val_q[5];

endmodule

// File: rtl/ibcc_checker.sv
// Port-level checks for the IMU bias calibration and scaling block.
// Depends on ibcc_pkg; bound to imu_bias_calibrate_convert_core below.
module ibcc_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [ibcc_pkg::STATUS_W-1:0]       status_o,
  input logic [ibcc_pkg::VAL_W-1:0]          accel_x_val_o,
  input logic [ibcc_pkg::VAL_W-1:0]          accel_y_val_o,
  input logic [ibcc_pkg::VAL_W-1:0]          accel_z_val_o,
  input logic [ibcc_pkg::VAL_W-1:0]          gyro_x_val_o,
  input logic [ibcc_pkg::VAL_W-1:0]          gyro_y_val_o,
  input logic [ibcc_pkg::VAL_W-1:0]          gyro_z_val_o
);

  function automatic logic fits16(input logic [ibcc_pkg::VAL_W-1:0] v);
    return (v[20:15] == 6'h00) || (v[20:15] == 6'h3f);
  endfunction

  logic vals_zero;
  logic vals_fit;

  assign vals_zero = (accel_x_val_o == '0) && (accel_y_val_o == '0) && (accel_z_val_o == '0)
                  && (gyro_x_val_o == '0) && (gyro_y_val_o == '0) && (gyro_z_val_o == '0);
  assign vals_fit  = fits16(accel_x_val_o) && fits16(accel_y_val_o) && fits16(accel_z_val_o)
                  && fits16(gyro_x_val_o) && fits16(gyro_y_val_o) && fits16(gyro_z_val_o);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted again in the cycle after a transfer");

  a_quiet_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ibcc_pkg::STATUS_CALIB_TAKEN
      || status_o == ibcc_pkg::STATUS_CALIB_FAIL || status_o == ibcc_pkg::STATUS_REJECTED)
    |-> vals_zero)
    else $error("non-zero values with a status that carries none");

  a_offsets_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ibcc_pkg::STATUS_CALIB_DONE) |-> vals_fit)
    else $error("reported offset is not a sign-extended 16-bit value");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(accel_x_val_o) && $stable(gyro_z_val_o))
    else $error("stalled result changed or was dropped");

endmodule

bind imu_bias_calibrate_convert_core ibcc_checker u_ibcc_checker (.*);

// File: tb/sv/imu_bias_calibrate_convert_core_test.sv
// Self-checking testbench for imu_bias_calibrate_convert_core: bias calibration runs and
// offset-corrected scaling, checked against a behavioural predictor of the block.
// Depends on ibcc_pkg and the RTL of the block; no other files.
module imu_bias_calibrate_convert_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OP_CALIB   = 1'b0;
  localparam logic OP_MEASURE = 1'b1;
  localparam longint VAL_HI   = 1048575;
  localparam longint VAL_LO   = -1048576;

  typedef struct packed {
    logic                                               op;
    logic                                               ok;
    logic [ibcc_pkg::NUM_CH-1:0][ibcc_pkg::RAW_W-1:0]   raw;
  } imu_sample_t;

  typedef struct packed {
    logic [ibcc_pkg::STATUS_W-1:0]                      status;
    logic [ibcc_pkg::NUM_CH-1:0][ibcc_pkg::VAL_W-1:0]   val;
  } imu_result_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_we_i = 1'b0;
  logic [ibcc_pkg::CFG_IX_W-1:0]     cfg_index_i = '0;
  logic [ibcc_pkg::CFG_D_W-1:0]      cfg_data_i = '0;
  logic                              in_valid_i = 1'b0;
  logic                              in_ready_o;
  logic                              op_i = 1'b0;
  logic                              sample_ok_i = 1'b0;
  logic signed [ibcc_pkg::RAW_W-1:0] accel_x_raw_i = '0;
  logic signed [ibcc_pkg::RAW_W-1:0] accel_y_raw_i = '0;
  logic signed [ibcc_pkg::RAW_W-1:0] accel_z_raw_i = '0;
  logic signed [ibcc_pkg::RAW_W-1:0] gyro_x_raw_i = '0;
  logic signed [ibcc_pkg::RAW_W-1:0] gyro_y_raw_i = '0;
  logic signed [ibcc_pkg::RAW_W-1:0] gyro_z_raw_i = '0;
  logic                              out_valid_o;
  logic                              out_ready_i = 1'b0;
  logic [ibcc_pkg::STATUS_W-1:0]     status_o;
  logic signed [ibcc_pkg::VAL_W-1:0] accel_x_val_o;
  logic signed [ibcc_pkg::VAL_W-1:0] accel_y_val_o;
  logic signed [ibcc_pkg::VAL_W-1:0] accel_z_val_o;
  logic signed [ibcc_pkg::VAL_W-1:0] gyro_x_val_o;
  logic signed [ibcc_pkg::VAL_W-1:0] gyro_y_val_o;
  logic signed [ibcc_pkg::VAL_W-1:0] gyro_z_val_o;

  imu_bias_calibrate_convert_core dut (.*);

  logic                              reg_present;
  logic [ibcc_pkg::CNT_W-1:0]        reg_calib_len;
  logic [ibcc_pkg::ONEG_W-1:0]       reg_one_g;
  logic [ibcc_pkg::GAIN_W-1:0]       reg_accel_gain;
  logic [ibcc_pkg::GAIN_W-1:0]       reg_gyro_gain;
  int                                bias_sum [ibcc_pkg::NUM_CH];
  logic signed [ibcc_pkg::RAW_W-1:0] bias_offset [ibcc_pkg::NUM_CH];
  logic [ibcc_pkg::CNT_W-1:0]        calib_seen;
  logic [ibcc_pkg::CNT_W-1:0]        calib_good;

  imu_sample_t samples_to_send [$];
  imu_result_t results_due [$];
  int          samples_queued = 0;
  int          samples_accepted = 0;
  int          results_checked = 0;
  int          mismatches = 0;
  int          send_gap_pct = 26;
  int          recv_stall_pct = 67;
  logic        sample_taken = 1'b0;

  initial begin
    reg_present    = 1'b0;
    reg_calib_len  = 16'd200;
    reg_one_g      = 15'd16384;
    reg_accel_gain = 24'd10042;
    reg_gyro_gain  = 24'd128075;
    for (int i = 0; i < ibcc_pkg::NUM_CH; i++) begin
      bias_sum[i]    = 0;
      bias_offset[i] = '0;
    end
    calib_seen = '0;
    calib_good = '0;
  end

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic imu_result_t bias_and_scale(input imu_sample_t s);
    imu_result_t                 r;
    int                          diff;
    int                          avg;
    longint                      prod;
    longint                      q;
    logic [ibcc_pkg::GAIN_W-1:0] gain;
    r = '0;
    r.status = ibcc_pkg::STATUS_REJECTED;
    if (!reg_present || (s.op == OP_MEASURE && !s.ok)) return r;
    if (s.op == OP_MEASURE) begin
      for (int i = 0; i < ibcc_pkg::NUM_CH; i++) begin
        gain = (i < 3) ? reg_accel_gain : reg_gyro_gain;
        diff = int'($signed(s.raw[i])) - int'(bias_offset[i]);
        prod = longint'(diff) * longint'(gain);
        q = prod >>> 16;
        if (q > VAL_HI) q = VAL_HI;
        else if (q < VAL_LO) q = VAL_LO;
        r.val[i] = q[ibcc_pkg::VAL_W-1:0];
      end
      r.status = ibcc_pkg::STATUS_MEASURED;
      return r;
    end
    if (s.ok) begin
      for (int i = 0; i < ibcc_pkg::NUM_CH; i++) bias_sum[i] += int'($signed(s.raw[i]));
      calib_good = calib_good + 1'b1;
    end
    calib_seen = calib_seen + 1'b1;
    if (calib_seen < reg_calib_len) begin
      r.status = ibcc_pkg::STATUS_CALIB_TAKEN;
      return r;
    end
    if (calib_good == '0) begin
      r.status = ibcc_pkg::STATUS_CALIB_FAIL;
    end else begin
      for (int i = 0; i < ibcc_pkg::NUM_CH; i++) begin
        avg = bias_sum[i] / int'(calib_good);
        if (i == 2) avg = avg - int'(reg_one_g);
        bias_offset[i] = avg[ibcc_pkg::RAW_W-1:0];
        r.val[i] = {{(ibcc_pkg::VAL_W-ibcc_pkg::RAW_W){bias_offset[i][ibcc_pkg::RAW_W-1]}},
                    bias_offset[i]};
      end
      r.status = ibcc_pkg::STATUS_CALIB_DONE;
    end
    for (int i = 0; i < ibcc_pkg::NUM_CH; i++) bias_sum[i] = 0;
    calib_seen = '0;
    calib_good = '0;
    return r;
  endfunction

  always @(negedge clk_i) begin : sample_driver
    imu_sample_t s;
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_ni && (!in_valid_i || sample_taken)) begin
      if (samples_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        s = samples_to_send.pop_front();
        op_i          <= s.op;
        sample_ok_i   <= s.ok;
        accel_x_raw_i <= s.raw[0];
        accel_y_raw_i <= s.raw[1];
        accel_z_raw_i <= s.raw[2];
        gyro_x_raw_i  <= s.raw[3];
        gyro_y_raw_i  <= s.raw[4];
        gyro_z_raw_i  <= s.raw[5];
        in_valid_i    <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : port_monitor
    imu_sample_t seen;
    imu_result_t got;
    imu_result_t want;
    logic        bad;
    sample_taken <= in_valid_i && in_ready_o;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.status = status_o;
      got.val[0] = accel_x_val_o;
      got.val[1] = accel_y_val_o;
      got.val[2] = accel_z_val_o;
      got.val[3] = gyro_x_val_o;
      got.val[4] = gyro_y_val_o;
      got.val[5] = gyro_z_val_o;
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transfer: status %0d values %h", got.status, got.val);
      end else begin
        want = results_due.pop_front();
        bad = (got.status !== want.status);
        for (int i = 0; i < ibcc_pkg::NUM_CH; i++) bad = bad | (got.val[i] !== want.val[i]);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected status %0d values %h, got status %0d values %h",
                     results_checked, want.status, want.val, got.status, got.val);
        end
      end
      results_checked++;
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      seen.op     = op_i;
      seen.ok     = sample_ok_i;
      seen.raw[0] = accel_x_raw_i;
      seen.raw[1] = accel_y_raw_i;
      seen.raw[2] = accel_z_raw_i;
      seen.raw[3] = gyro_x_raw_i;
      seen.raw[4] = gyro_y_raw_i;
      seen.raw[5] = gyro_z_raw_i;
      results_due.push_back(bias_and_scale(seen));
      samples_accepted++;
    end
  end

  task automatic write_reg(input logic [ibcc_pkg::CFG_IX_W-1:0] ix,
                           input logic [ibcc_pkg::CFG_D_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= ix;
    cfg_data_i  <= value;
    case (ix)
      ibcc_pkg::CFG_SENSOR_PRESENT: reg_present    = value[0];
      ibcc_pkg::CFG_CALIB_SAMPLES:  reg_calib_len  = value[ibcc_pkg::CNT_W-1:0];
      ibcc_pkg::CFG_ACCEL_ONE_G:    reg_one_g      = value[ibcc_pkg::ONEG_W-1:0];
      ibcc_pkg::CFG_ACCEL_GAIN:     reg_accel_gain = value[ibcc_pkg::GAIN_W-1:0];
      ibcc_pkg::CFG_GYRO_GAIN:      reg_gyro_gain  = value[ibcc_pkg::GAIN_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic void push_sample(input logic op, input logic ok,
      input logic [ibcc_pkg::NUM_CH-1:0][ibcc_pkg::RAW_W-1:0] raw);
    imu_sample_t s;
    s.op  = op;
    s.ok  = ok;
    s.raw = raw;
    samples_to_send.push_back(s);
    samples_queued++;
  endfunction

  function automatic void push_random_sample();
    logic [ibcc_pkg::NUM_CH-1:0][ibcc_pkg::RAW_W-1:0] raw;
    int                                               kind;
    int                                               base;
    kind = $urandom_range(9);
    for (int i = 0; i < ibcc_pkg::NUM_CH; i++) begin
      base = (i == 2) ? 16384 : 0;
      case (kind)
        0:       raw[i] = $urandom_range(1) ? 16'h7fff : 16'h8000;
        1, 2, 3: raw[i] = 16'($urandom());
        default: raw[i] = 16'(base + int'($urandom_range(1023)) - 512);
      endcase
    end
    push_sample(($urandom_range(99) < 45) ? OP_CALIB : OP_MEASURE,
                ($urandom_range(99) < 90), raw);
  endfunction

  task automatic wait_drained();
    while (!(samples_accepted == samples_queued && results_due.size() == 0))
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic random_setup();
    int pick;
    write_reg(ibcc_pkg::CFG_SENSOR_PRESENT, ibcc_pkg::CFG_D_W'($urandom_range(19) != 0));
    pick = $urandom_range(9);
    case (pick)
      0:       write_reg(ibcc_pkg::CFG_CALIB_SAMPLES,
                         ibcc_pkg::CFG_D_W'($urandom_range(1)));
      8, 9:    write_reg(ibcc_pkg::CFG_CALIB_SAMPLES,
                         ibcc_pkg::CFG_D_W'($urandom_range(13, 40)));
      default: write_reg(ibcc_pkg::CFG_CALIB_SAMPLES,
                         ibcc_pkg::CFG_D_W'($urandom_range(2, 12)));
    endcase
    if ($urandom_range(3) == 0)
      write_reg(ibcc_pkg::CFG_ACCEL_ONE_G, $urandom_range(1) ? 24'd1 : 24'd32767);
    else
      write_reg(ibcc_pkg::CFG_ACCEL_ONE_G, ibcc_pkg::CFG_D_W'($urandom_range(1, 32767)));
    for (int g = 0; g < 2; g++) begin
      case ($urandom_range(3))
        0:       pick = $urandom_range(1) ? 0 : 24'hffffff;
        1:       pick = $urandom_range(24'hffffff);
        default: pick = $urandom_range(5000, 200000);
      endcase
      write_reg((g == 0) ? ibcc_pkg::CFG_ACCEL_GAIN : ibcc_pkg::CFG_GYRO_GAIN,
                ibcc_pkg::CFG_D_W'(pick));
    end
  endtask

  initial begin : stimulus
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    push_sample(OP_MEASURE, 1'b1, {ibcc_pkg::NUM_CH{16'h7fff}});
    push_sample(OP_CALIB, 1'b1, {ibcc_pkg::NUM_CH{16'h8000}});
    wait_drained();

    write_reg(ibcc_pkg::CFG_SENSOR_PRESENT, 24'd1);
    push_sample(OP_MEASURE, 1'b1, {ibcc_pkg::NUM_CH{16'h7fff}});
    push_sample(OP_MEASURE, 1'b1, {ibcc_pkg::NUM_CH{16'h8000}});
    push_sample(OP_MEASURE, 1'b1,
                {16'h1234, 16'h0000, 16'hffff, 16'h0001, 16'h8000, 16'h7fff});
    push_sample(OP_MEASURE, 1'b0, {ibcc_pkg::NUM_CH{16'h4000}});
    wait_drained();

    write_reg(ibcc_pkg::CFG_CALIB_SAMPLES, 24'd3);
    push_sample(OP_CALIB, 1'b1, {ibcc_pkg::NUM_CH{16'h7fff}});
    push_sample(OP_CALIB, 1'b0, {ibcc_pkg::NUM_CH{16'h8000}});
    push_sample(OP_CALIB, 1'b1, {ibcc_pkg::NUM_CH{16'h8000}});
    push_sample(OP_CALIB, 1'b0, {ibcc_pkg::NUM_CH{16'h1111}});
    push_sample(OP_CALIB, 1'b0, {ibcc_pkg::NUM_CH{16'h2222}});
    push_sample(OP_CALIB, 1'b0, {ibcc_pkg::NUM_CH{16'h3333}});
    push_sample(OP_MEASURE, 1'b1, {ibcc_pkg::NUM_CH{16'h8000}});
    push_sample(OP_MEASURE, 1'b1,
                {16'hfffe, 16'h0003, 16'h3fff, 16'h8001, 16'h0002, 16'hffff});
    wait_drained();

    write_reg(ibcc_pkg::CFG_ACCEL_GAIN, 24'hffffff);
    write_reg(ibcc_pkg::CFG_GYRO_GAIN, 24'hffffff);
    push_sample(OP_MEASURE, 1'b1, {ibcc_pkg::NUM_CH{16'h7fff}});
    push_sample(OP_MEASURE, 1'b1, {ibcc_pkg::NUM_CH{16'h8000}});
    wait_drained();
    write_reg(ibcc_pkg::CFG_ACCEL_GAIN, 24'd0);
    write_reg(ibcc_pkg::CFG_GYRO_GAIN, 24'd0);
    push_sample(OP_MEASURE, 1'b1, {ibcc_pkg::NUM_CH{16'h7fff}});
    wait_drained();

    write_reg(ibcc_pkg::CFG_ACCEL_ONE_G, 24'd32767);
    write_reg(ibcc_pkg::CFG_CALIB_SAMPLES, 24'd1);
    push_sample(OP_CALIB, 1'b1, {ibcc_pkg::NUM_CH{16'h8000}});
    wait_drained();
    write_reg(ibcc_pkg::CFG_ACCEL_ONE_G, 24'd1);
    push_sample(OP_CALIB, 1'b1,
                {16'h0123, 16'hff00, 16'h0040, 16'h4000, 16'h8000, 16'h7fff});
    wait_drained();

    write_reg(ibcc_pkg::CFG_CALIB_SAMPLES, 24'd0);
    push_sample(OP_CALIB, 1'b0, {ibcc_pkg::NUM_CH{16'h5555}});
    push_sample(OP_CALIB, 1'b1, {ibcc_pkg::NUM_CH{16'haaaa}});
    wait_drained();

    write_reg(ibcc_pkg::CFG_CALIB_SAMPLES, 24'd65535);
    write_reg(ibcc_pkg::CFG_ACCEL_GAIN, 24'd10042);
    write_reg(ibcc_pkg::CFG_GYRO_GAIN, 24'd128075);
    push_sample(OP_CALIB, 1'b1, {ibcc_pkg::NUM_CH{16'h0100}});
    push_sample(OP_CALIB, 1'b1, {ibcc_pkg::NUM_CH{16'hff00}});
    wait_drained();
    write_reg(ibcc_pkg::CFG_CALIB_SAMPLES, 24'd1);
    push_sample(OP_CALIB, 1'b1, {ibcc_pkg::NUM_CH{16'h0203}});
    push_sample(OP_MEASURE, 1'b1, {ibcc_pkg::NUM_CH{16'h0000}});
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      send_gap_pct   = (ph == 0) ? 26 : (ph == 1) ? 67 : 0;
      recv_stall_pct = (ph == 0) ? 67 : (ph == 1) ? 26 : 0;
      for (int chunk = 0; chunk < 4; chunk++) begin
        random_setup();
        repeat (100) push_random_sample();
        wait_drained();
      end
    end

    repeat (300) @(negedge clk_i);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
